// ----- rtl/mlr_pkg.sv -----
// ============================================================================
// mlr_pkg - shared types and helpers for the momentary layer resolver
// Widths, command codes, the classified op passed from front to back, the
// candidate record of the resolve tree and the layer stepping helpers.
// ============================================================================
package mlr_pkg;

    localparam int KEYS      = 16;
    localparam int LAYERS    = 8;

    localparam int CMD_W     = 2;
    localparam int KEY_IN_W  = 4;
    localparam int LAYER_W   = 3;
    localparam int MASK_W    = 8;
    localparam int ORDER_W   = 32;

    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    localparam int KEY_LVLS  = (KEYS > 1) ? $clog2(KEYS) : 0;
    localparam int KEY_IDX_W = (KEYS > 1) ? KEY_LVLS : 1;
    localparam int CNT_W     = (KEY_LVLS > 0) ? $clog2(KEY_LVLS + 1) : 1;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PRESS    = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_CYC_FWD  = 2'd2,
        CMD_CYC_BACK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_PRESS,
        OP_RELEASE,
        OP_CYCLE
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [KEY_IDX_W-1:0]   key;
        logic [LAYER_W-1:0]     src;
        logic [LAYER_W-1:0]     tgt;
        logic                   fwd;
    } op_t;

    typedef struct packed {
        logic                   vld;
        logic [ORDER_W-1:0]     ord;
        logic [LAYER_W-1:0]     tgt;
    } cand_t;

    function automatic logic layer_ok(input logic [LAYER_W-1:0] layer,
                                      input logic [MASK_W-1:0]  mask);
        return (32'(layer) < 32'(LAYERS)) && mask[layer];
    endfunction

    // small table: x mod LAYERS for x below 16
    function automatic logic [LAYER_W-1:0] mod_layers(input logic [3:0] x);
        logic [LAYER_W-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (x == 4'(i)) r = LAYER_W'(i % LAYERS);
        end
        return r;
    endfunction

    // next or previous enabled layer with wrap, layer 0 when none enabled
    function automatic logic [LAYER_W-1:0] step_layer(input logic [LAYER_W-1:0] from,
                                                      input logic               fwd,
                                                      input logic [MASK_W-1:0]  mask);
        logic [LAYER_W-1:0] cur;
        logic [LAYER_W-1:0] res;
        logic               found;
        cur   = mod_layers({1'b0, from});
        res   = '0;
        found = 1'b0;
        for (int off = 1; off <= LAYERS; off++) begin
            if (fwd) begin
                cur = (cur == LAYER_W'(LAYERS - 1)) ? '0 : cur + 1'b1;
            end else begin
                cur = (cur == '0) ? LAYER_W'(LAYERS - 1) : cur - 1'b1;
            end
            if (!found && layer_ok(cur, mask)) begin
                res   = cur;
                found = 1'b1;
            end
        end
        return res;
    endfunction

    // a is the lower key index; the higher index wins a tie
    function automatic cand_t cand_pick(input cand_t a, input cand_t b);
        if (b.vld && (!a.vld || (b.ord >= a.ord))) return b;
        return a;
    endfunction

endpackage

// ----- rtl/mlr_front.sv -----
// ============================================================================
// mlr_front - input side of the layer resolver
// Accepts command beats and classifies them into ops for the back end:
// presses on disabled layers and keys out of range become no-ops.
// ============================================================================
module mlr_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mlr_pkg::S_DATA_W-1:0]       s_tdata,   // command, key_index, source, target
    input  logic [mlr_pkg::MASK_W-1:0]         mask,
    input  logic                               q_full,
    output logic                               q_push,
    output mlr_pkg::op_t                       q_op
);

    mlr_pkg::cmd_t                     cmd;
    logic [mlr_pkg::KEY_IN_W-1:0]      key_in;
    logic                              key_ok;

    assign cmd    = mlr_pkg::cmd_t'(s_tdata[1:0]);
    assign key_in = s_tdata[5:2];
    assign key_ok = 32'(key_in) < 32'(mlr_pkg::KEYS);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_op.key  = mlr_pkg::KEY_IDX_W'(key_in);
        q_op.src  = s_tdata[8:6];
        q_op.tgt  = s_tdata[11:9];
        q_op.fwd  = 1'b0;
        q_op.kind = mlr_pkg::OP_NOP;
        unique case (cmd)
            mlr_pkg::CMD_PRESS: begin
                if (key_ok && mlr_pkg::layer_ok(s_tdata[11:9], mask)) begin
                    q_op.kind = mlr_pkg::OP_PRESS;
                end
            end
            mlr_pkg::CMD_RELEASE: begin
                if (key_ok) q_op.kind = mlr_pkg::OP_RELEASE;
            end
            mlr_pkg::CMD_CYC_FWD: begin
                q_op.kind = mlr_pkg::OP_CYCLE;
                q_op.fwd  = 1'b1;
            end
            mlr_pkg::CMD_CYC_BACK: begin
                q_op.kind = mlr_pkg::OP_CYCLE;
            end
        endcase
    end

endmodule

// ----- rtl/mlr_queue.sv -----
// ============================================================================
// mlr_queue - op queue between front and back
// Short fifo of classified ops so that intake and execution stall apart.
// ============================================================================
module mlr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mlr_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output mlr_pkg::op_t  q_op
);

    mlr_pkg::op_t                  entry_reg [mlr_pkg::QDEPTH];
    logic [mlr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mlr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mlr_pkg::QCNT_W-1:0]    count_reg;
    logic [mlr_pkg::QCNT_W-1:0]    count_next;

    assign full    = (count_reg == mlr_pkg::QCNT_W'(mlr_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == mlr_pkg::QPTR_W'(mlr_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == mlr_pkg::QPTR_W'(mlr_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mlr_tree.sv -----
// ============================================================================
// mlr_tree - registered max tree over the key entries
// Finds the held key with the largest press order, highest index on a tie.
// One register level per tree level, free running.
// ============================================================================
module mlr_tree (
    input  logic                                aclk,
    input  logic [mlr_pkg::KEYS-1:0]            held,
    input  logic [mlr_pkg::ORDER_W-1:0]         order [mlr_pkg::KEYS],
    input  logic [mlr_pkg::LAYER_W-1:0]         target [mlr_pkg::KEYS],
    output logic                                found,
    output logic [mlr_pkg::LAYER_W-1:0]         found_tgt
);

    localparam int LEAVES = 1 << mlr_pkg::KEY_LVLS;

    // heap order: root at 1, leaves at LEAVES and up
    mlr_pkg::cand_t node [1:2*LEAVES-1];

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < mlr_pkg::KEYS) begin : g_key
            assign node[LEAVES+i] = '{vld: held[i], ord: order[i], tgt: target[i]};
        end else begin : g_pad
            assign node[LEAVES+i] = '0;
        end
    end

    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        always_ff @(posedge aclk) begin
            node[n] <= mlr_pkg::cand_pick(node[2*n], node[2*n+1]);
        end
    end

    assign found     = node[1].vld;
    assign found_tgt = node[1].tgt;

endmodule

// ----- rtl/mlr_back.sv -----
// ============================================================================
// mlr_back - execution side of the layer resolver
// Holds the key table, order counter, base and active layer. Runs one op at
// a time, waits on the resolve tree when needed and drives the result beat.
// ============================================================================
module mlr_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [mlr_pkg::MASK_W-1:0]         mask,
    input  logic                               q_valid,
    input  mlr_pkg::op_t                       q_op,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mlr_pkg::M_DATA_W-1:0]       m_tdata    // current_layer, release_matched, any_held
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TREE,
        S_EMIT
    } state_t;

    state_t                              state_reg;
    logic [mlr_pkg::CNT_W-1:0]           cnt_reg;
    logic [mlr_pkg::KEYS-1:0]            held_reg;
    logic [mlr_pkg::LAYER_W-1:0]         target_reg [mlr_pkg::KEYS];
    logic [mlr_pkg::ORDER_W-1:0]         order_reg [mlr_pkg::KEYS];
    logic [mlr_pkg::ORDER_W-1:0]         counter_reg;
    logic [mlr_pkg::LAYER_W-1:0]         base_reg;
    logic [mlr_pkg::LAYER_W-1:0]         active_reg;
    logic                                matched_reg;
    logic                                m_tvalid_reg;
    logic [mlr_pkg::M_DATA_W-1:0]        m_tdata_reg;

    logic                                any_held;
    logic                                key_hit;
    logic [mlr_pkg::LAYER_W-1:0]         step_res;
    logic                                out_free;
    logic                                emit_fire;
    logic                                tree_found;
    logic [mlr_pkg::LAYER_W-1:0]         tree_tgt;

    mlr_tree u_tree (
        .aclk      (aclk),
        .held      (held_reg),
        .order     (order_reg),
        .target    (target_reg),
        .found     (tree_found),
        .found_tgt (tree_tgt)
    );

    assign any_held = |held_reg;
    assign key_hit  = held_reg[q_op.key];
    // with keys held the cycle moves the base, otherwise the active layer
    assign step_res = mlr_pkg::step_layer(any_held ? base_reg : active_reg, q_op.fwd, mask);
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            unique case (q_op.kind)
                mlr_pkg::OP_PRESS: begin
                    target_reg[q_op.key] <= q_op.tgt;
                    order_reg[q_op.key]  <= counter_reg;
                end
                mlr_pkg::OP_RELEASE: begin
                    if (key_hit) order_reg[q_op.key] <= '0;
                end
                mlr_pkg::OP_CYCLE, mlr_pkg::OP_NOP: begin
                end
            endcase
        end
        if (emit_fire) begin
            m_tdata_reg <= mlr_pkg::M_DATA_W'({any_held, matched_reg, active_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            held_reg     <= '0;
            counter_reg  <= mlr_pkg::ORDER_W'(1);
            base_reg     <= '0;
            active_reg   <= '0;
            matched_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        matched_reg <= (q_op.kind == mlr_pkg::OP_RELEASE) && key_hit;
                        cnt_reg     <= '0;
                        unique case (q_op.kind)
                            mlr_pkg::OP_PRESS: begin
                                if (!any_held) base_reg <= q_op.src;
                                held_reg[q_op.key] <= 1'b1;
                                counter_reg        <= counter_reg + 1'b1;
                                state_reg          <= S_TREE;
                            end
                            mlr_pkg::OP_RELEASE: begin
                                if (key_hit) begin
                                    held_reg[q_op.key] <= 1'b0;
                                    state_reg          <= S_TREE;
                                end else begin
                                    state_reg          <= S_EMIT;
                                end
                            end
                            mlr_pkg::OP_CYCLE: begin
                                if (any_held) begin
                                    base_reg  <= step_res;
                                    state_reg <= S_TREE;
                                end else begin
                                    active_reg <= step_res;
                                    state_reg  <= S_EMIT;
                                end
                            end
                            mlr_pkg::OP_NOP: begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_TREE: begin
                    // root is valid once the new key state has crossed every level
                    if (cnt_reg == mlr_pkg::CNT_W'(mlr_pkg::KEY_LVLS)) begin
                        active_reg <= tree_found ? tree_tgt : base_reg;
                        state_reg  <= S_EMIT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/momentary_layer_resolver.sv -----
// op path: a beat is pushed into the op queue, popped by the back end in S_IDLE
// and sent out in S_EMIT, by way of S_TREE for a press, a matched release or a
// cycle with keys held, where the layer is resolved through the registered max
// tree, one register level per tree level; one op is in the back end at a time
// reset: synchronous active-low aresetn clears keys, layers and queue;
// enabled layer mask resets to layer 0 only
// ============================================================================
// momentary_layer_resolver - keyboard momentary layer stack
// Front classifies command beats into a short op queue; the back end keeps
// the held keys, resolves the current layer and returns one beat per command.
// ============================================================================
module momentary_layer_resolver (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mlr_pkg::MASK_W-1:0]         cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mlr_pkg::S_DATA_W-1:0]       s_tdata,   // command, key_index, source_layer, target_layer
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mlr_pkg::M_DATA_W-1:0]       m_tdata    // current_layer, release_matched, any_held
);

    logic [mlr_pkg::MASK_W-1:0]  mask_reg;
    logic                        q_full;
    logic                        q_push;
    mlr_pkg::op_t                push_op;
    logic                        q_valid;
    logic                        q_pop;
    mlr_pkg::op_t                q_op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= mlr_pkg::MASK_W'(1);
        end else if (cfg_wr_en) begin
            mask_reg <= cfg_wr_data;
        end
    end

    mlr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .mask     (mask_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    mlr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    mlr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mask     (mask_reg),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // back end never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("op popped from empty queue");

    // an accepted beat is waiting in the queue on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (s_tvalid && s_tready) |=> q_valid)
        else $error("accepted beat missing from op queue");

    // a push without a pop never lands on a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (q_push && !q_pop) |=> !$past(q_full))
        else $error("push into full op queue");

endmodule
